@@ hw/rtl/sdq_pkg.sv @@
// Shared types and constants of the searchable deque.
package sdq_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_PUSH   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

@@ hw/rtl/sdq_if.sv @@
// Request and response channel interfaces of the searchable deque.
interface sdq_req_if;
  logic                                valid;
  logic                                ready;
  logic [sdq_pkg::KIND_W-1:0]          kind;
  logic signed [sdq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface sdq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [sdq_pkg::STATUS_W-1:0]        status;
  logic signed [sdq_pkg::VALUE_W-1:0]  removed_value;
  logic [sdq_pkg::POS_W-1:0]           found_position;
  logic [sdq_pkg::POS_W-1:0]           occupancy;

  modport source (output valid, status, removed_value, found_position, occupancy,
                  input ready);
  modport sink   (input valid, status, removed_value, found_position, occupancy,
                  output ready);
endinterface

@@ hw/rtl/searchable_deque_core.sv @@
// Bounded double-ended queue in a ring memory, with a linear search from the front.
//
//   channel  direction  payload                                          handshake
//   req      in         kind, value                                      valid/ready
//   rsp      out        status, removed_value, found_position, occupancy  valid/ready
//
// Append, push and any rejected request: the result is registered at accept.
// Remove: the read of the single memory read port is registered, then the result is registered in S_READ.
// Search: entries are read and compared from the front until a match or the last entry;
// the one read port and one 32-bit comparator look at one entry per cycle.
// Reset (rst, synchronous) empties the queue; memory contents are not cleared.
// A new request is taken only while idle and with the result register free or draining.
module searchable_deque_core #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  sdq_req_if.sink  req,
  sdq_rsp_if.source rsp
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int PosW = sdq_pkg::POS_W;
  localparam int ValW = sdq_pkg::VALUE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH
  } state_t;

  typedef struct packed {
    sdq_pkg::status_t  status;
    logic [ValW-1:0]   removed;
    logic [PosW-1:0]   position;
    logic [PosW-1:0]   occupancy;
  } result_t;

  state_t           state;
  result_t          res;
  logic             out_valid;
  logic [PW-1:0]    front;
  logic [CW-1:0]    count;
  logic [CW-1:0]    scan;
  logic [CW-1:0]    cmp;
  logic             rd_valid;
  logic [ValW-1:0]  value_q;

  logic [ValW-1:0]  mem [DEPTH];
  logic [ValW-1:0]  rd_data;

  logic             accept;
  logic             full;
  logic             empty;
  logic [PW-1:0]    front_dec;
  logic             mem_we;
  logic [PW-1:0]    waddr;
  logic [PW-1:0]    raddr;
  logic             res_load;
  sdq_pkg::kind_t   kind_in;

  // Offsets of the used accesses stay at or below DEPTH, so one conditional subtract wraps the sum.
  function automatic logic [PW-1:0] ring_idx(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign kind_in   = sdq_pkg::kind_t'(req.kind);
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? PW'(DEPTH - 1) : front - PW'(1);

  assign mem_we = accept && !full &&
                  (kind_in inside {sdq_pkg::KIND_APPEND, sdq_pkg::KIND_PUSH});
  assign waddr  = (kind_in == sdq_pkg::KIND_PUSH) ? front_dec : ring_idx(front, count);
  assign raddr  = (state == S_SEARCH) ? ring_idx(front, scan)
                                      : ring_idx(front, count - CW'(1));

  // The result register loads when a request finishes and otherwise drains on a handshake.
  always_comb begin
    res_load = 1'b0;
    case (state)
      S_IDLE: begin
        res_load = accept &&
                   ((kind_in inside {sdq_pkg::KIND_APPEND, sdq_pkg::KIND_PUSH}) || empty);
      end
      S_READ: begin
        res_load = 1'b1;
      end
      S_SEARCH: begin
        res_load = rd_valid && ((rd_data == value_q) || (cmp + CW'(1) == count));
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= req.value;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      front     <= '0;
      count     <= '0;
      scan      <= '0;
      cmp       <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            value_q <= req.value;
            case (kind_in)
              sdq_pkg::KIND_APPEND, sdq_pkg::KIND_PUSH: begin
                if (full) begin
                  res <= '{sdq_pkg::ST_FULL, '0, '0, PosW'(count)};
                end else begin
                  count <= count + CW'(1);
                  res   <= '{sdq_pkg::ST_DONE, '0, '0, PosW'(count + CW'(1))};
                  if (kind_in == sdq_pkg::KIND_PUSH) begin
                    front <= front_dec;
                  end
                end
              end
              sdq_pkg::KIND_REMOVE: begin
                if (empty) begin
                  res <= '{sdq_pkg::ST_EMPTY, '0, '0, '0};
                end else begin
                  count <= count - CW'(1);
                  state <= S_READ;
                end
              end
              default: begin
                if (empty) begin
                  res <= '{sdq_pkg::ST_NOT_FOUND, '0, '0, '0};
                end else begin
                  scan     <= '0;
                  cmp      <= '0;
                  rd_valid <= 1'b0;
                  state    <= S_SEARCH;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res   <= '{sdq_pkg::ST_DONE, rd_data, '0, PosW'(count)};
          state <= S_IDLE;
        end
        S_SEARCH: begin
          // Reads are issued one entry ahead of the compare.
          rd_valid <= (scan < count);
          if (scan < count) begin
            scan <= scan + CW'(1);
          end
          if (rd_valid) begin
            if (rd_data == value_q) begin
              res   <= '{sdq_pkg::ST_DONE, '0, PosW'(cmp + CW'(1)), PosW'(count)};
              state <= S_IDLE;
            end else if (cmp + CW'(1) == count) begin
              res   <= '{sdq_pkg::ST_NOT_FOUND, '0, '0, PosW'(count)};
              state <= S_IDLE;
            end else begin
              cmp <= cmp + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = res.status;
  assign rsp.removed_value  = res.removed;
  assign rsp.found_position = res.position;
  assign rsp.occupancy      = res.occupancy;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stored count exceeds depth");

  a_read_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> rsp.valid)
    else $error("removal did not produce a result");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (cmp <= scan) && (scan <= count))
    else $error("search compare index ran ahead of read index");

  a_not_found_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == sdq_pkg::ST_NOT_FOUND)) |-> (rsp.found_position == '0))
    else $error("position reported without a match");
`endif

endmodule

@@ bench/searchable_deque_core_tb.sv @@
// Self-checking testbench for the searchable deque core: directed edge cases and random traffic.
`timescale 1ns / 100ps

module searchable_deque_core_tb;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = sdq_pkg::VALUE_W;
  localparam int POS_W   = sdq_pkg::POS_W;
  localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef struct {
    sdq_pkg::status_t           status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [POS_W-1:0]           found_position;
    logic [POS_W-1:0]           occupancy;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst;

  sdq_req_if req_ch();
  sdq_rsp_if rsp_ch();

  searchable_deque_core #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the deque, updated when a request is accepted.
  logic signed [VALUE_W-1:0] shadow_ring [DEPTH];
  int unsigned               shadow_front = 0;
  int unsigned               shadow_count = 0;

  deque_result_t pending_results[$];
  int unsigned   mismatch_count = 0;

  bit          source_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned sink_hold_cycles = 0;

  int unsigned kind_tally [4] = '{0, 0, 0, 0};
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned search_hits = 0;
  int unsigned search_misses = 0;
  int unsigned peak_occupancy = 0;

  function automatic deque_result_t apply_deque_request(sdq_pkg::kind_t k,
                                                        logic signed [VALUE_W-1:0] v);
    deque_result_t r;
    r.status         = sdq_pkg::ST_DONE;
    r.removed_value  = '0;
    r.found_position = '0;
    case (k)
      sdq_pkg::KIND_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = sdq_pkg::ST_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_count) % DEPTH] = v;
          shadow_count++;
        end
      end
      sdq_pkg::KIND_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = sdq_pkg::ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = v;
          shadow_count++;
        end
      end
      sdq_pkg::KIND_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = sdq_pkg::ST_EMPTY;
        end else begin
          r.removed_value = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
          shadow_count--;
        end
      end
      default: begin
        r.status = sdq_pkg::ST_NOT_FOUND;
        for (int i = 0; i < shadow_count && r.status == sdq_pkg::ST_NOT_FOUND; i++) begin
          if (shadow_ring[(shadow_front + i) % DEPTH] == v) begin
            r.status         = sdq_pkg::ST_DONE;
            r.found_position = POS_W'(i + 1);
          end
        end
      end
    endcase
    r.occupancy = POS_W'(shadow_count);
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Often small values so that searches find duplicates, plus full-width and extreme ones.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 16)) - 8;
    if (roll < 8) return $urandom();
    case ($urandom_range(0, 3))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] stored_value(int unsigned pos);
    return shadow_ring[(shadow_front + pos) % DEPTH];
  endfunction

  // Offers one request and holds it until the core takes it.
  task automatic send_request(sdq_pkg::kind_t k, logic signed [VALUE_W-1:0] v);
    deque_result_t want;
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    want = apply_deque_request(k, v);
    pending_results.push_back(want);
    kind_tally[k]++;
    if (want.status == sdq_pkg::ST_FULL) full_rejects++;
    if (want.status == sdq_pkg::ST_EMPTY) empty_rejects++;
    if (k == sdq_pkg::KIND_SEARCH) begin
      if (want.status == sdq_pkg::ST_DONE) search_hits++;
      else search_misses++;
    end
    if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
    if (source_gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : response_check
    deque_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("response arrived with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          flag_mismatch($sformatf("status: expected %0d, got %0d",
                                  want.status, rsp_ch.status));
        if (rsp_ch.removed_value !== want.removed_value)
          flag_mismatch($sformatf("removed_value: expected %0d, got %0d",
                                  want.removed_value, rsp_ch.removed_value));
        if (rsp_ch.found_position !== want.found_position)
          flag_mismatch($sformatf("found_position: expected %0d, got %0d",
                                  want.found_position, rsp_ch.found_position));
        if (rsp_ch.occupancy !== want.occupancy)
          flag_mismatch($sformatf("occupancy: expected %0d, got %0d",
                                  want.occupancy, rsp_ch.occupancy));
      end
    end
  end

  initial begin : response_ready_driver
    int unsigned wait_cycles;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles != 0) begin
        wait_cycles = sink_hold_cycles;
        sink_hold_cycles = 0;
        rsp_ch.ready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        wait_cycles = $urandom_range(1, 5);
        rsp_ch.ready <= 1'b0;
      end else begin
        wait_cycles = 1;
        rsp_ch.ready <= 1'b1;
      end
      repeat (wait_cycles) @(posedge clk);
    end
  end

  task automatic test_empty_cases();
    send_request(sdq_pkg::KIND_SEARCH, '0);
    send_request(sdq_pkg::KIND_REMOVE, 32'sd7);
    send_request(sdq_pkg::KIND_PUSH, INT_MIN);
    send_request(sdq_pkg::KIND_SEARCH, INT_MIN);
    send_request(sdq_pkg::KIND_REMOVE, '0);
    send_request(sdq_pkg::KIND_REMOVE, '0);
  endtask

  task automatic test_extreme_values();
    send_request(sdq_pkg::KIND_APPEND, INT_MAX);
    send_request(sdq_pkg::KIND_APPEND, -1);
    send_request(sdq_pkg::KIND_APPEND, '0);
    send_request(sdq_pkg::KIND_APPEND, 32'sh5555_5555);
    send_request(sdq_pkg::KIND_PUSH, 32'shaaaa_aaaa);
    send_request(sdq_pkg::KIND_APPEND, -1);
    send_request(sdq_pkg::KIND_SEARCH, -1);
    send_request(sdq_pkg::KIND_SEARCH, 32'sh5555_5555);
    send_request(sdq_pkg::KIND_SEARCH, 32'sd12345);
    send_request(sdq_pkg::KIND_REMOVE, '0);
    send_request(sdq_pkg::KIND_REMOVE, '0);
  endtask

  // Fill from both ends so the front pointer wraps, then probe the full store.
  task automatic test_full_store();
    while (shadow_count < DEPTH) begin
      send_request(shadow_count % 2 ? sdq_pkg::KIND_PUSH : sdq_pkg::KIND_APPEND,
                   32'sd1000 + signed'(shadow_count));
    end
    send_request(sdq_pkg::KIND_APPEND, INT_MAX);
    send_request(sdq_pkg::KIND_PUSH, INT_MIN);
    send_request(sdq_pkg::KIND_SEARCH, stored_value(DEPTH - 1));
    send_request(sdq_pkg::KIND_SEARCH, stored_value(0));
    send_request(sdq_pkg::KIND_SEARCH, -1);
    send_request(sdq_pkg::KIND_REMOVE, '0);
    send_request(sdq_pkg::KIND_REMOVE, '0);
  endtask

  // The response side stops for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    sink_hold_cycles = 100;
    for (int n = 0; n < 30; n++) begin
      case (n % 3)
        0: send_request(sdq_pkg::KIND_APPEND, pick_value());
        1: send_request(sdq_pkg::KIND_SEARCH, pick_value());
        default: send_request(sdq_pkg::KIND_REMOVE, '0);
      endcase
    end
  endtask

  // Phases lean toward filling, draining or a mix, so occupancy sweeps its whole range.
  task automatic test_random_traffic(int unsigned item_count);
    int unsigned fill_pct;
    int unsigned remove_pct;
    int unsigned roll;
    sdq_pkg::kind_t k;
    logic signed [VALUE_W-1:0] v;
    fill_pct = 35;
    remove_pct = 30;
    for (int unsigned n = 0; n < item_count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: begin fill_pct = 60; remove_pct = 15; end
          1: begin fill_pct = 20; remove_pct = 55; end
          default: begin fill_pct = 35; remove_pct = 30; end
        endcase
      end
      if (n + 150 == item_count) begin
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
      end
      roll = $urandom_range(0, 99);
      if (roll < fill_pct)
        k = $urandom_range(0, 1) ? sdq_pkg::KIND_PUSH : sdq_pkg::KIND_APPEND;
      else if (roll < fill_pct + remove_pct) k = sdq_pkg::KIND_REMOVE;
      else k = sdq_pkg::KIND_SEARCH;
      if (k == sdq_pkg::KIND_SEARCH && shadow_count > 0 && $urandom_range(0, 3) != 0)
        v = stored_value($urandom_range(0, shadow_count - 1));
      else
        v = pick_value();
      send_request(k, v);
    end
  endtask

  initial begin : stimulus
    req_ch.valid <= 1'b0;
    req_ch.kind  <= sdq_pkg::KIND_APPEND;
    req_ch.value <= '0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_cases();
    test_extreme_values();
    test_full_store();
    test_output_backpressure();
    test_random_traffic(960);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Requests: %0d append, %0d push, %0d remove, %0d search; peak occupancy %0d.",
             kind_tally[sdq_pkg::KIND_APPEND], kind_tally[sdq_pkg::KIND_PUSH],
             kind_tally[sdq_pkg::KIND_REMOVE], kind_tally[sdq_pkg::KIND_SEARCH],
             peak_occupancy);
    $display("Rejected: %0d full, %0d empty; searches: %0d hit, %0d miss; %0d mismatches.",
             full_rejects, empty_rejects, search_hits, search_misses, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("Timed out with %0d responses outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
